[rtl/epmc_pkg.sv]
// ----------------------------------------------------------------------------
// epmc_pkg: shared types and constants of the motor speed controller
// Command codes, register indexes, sequencer states and default parameters.
// ----------------------------------------------------------------------------
package epmc_pkg;

  localparam int MOTORS_DEF     = 2;
  localparam int MAX_FORCE_DEF  = 1000;
  localparam int PWM_PERIOD_DEF = 1000;
  localparam int PID_RESET_MAG  = 10000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] CMD_EDGE   = 3'd0;
  localparam logic [2:0] CMD_TICK   = 3'd1;
  localparam logic [2:0] CMD_MOVE   = 3'd2;
  localparam logic [2:0] CMD_TARGET = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_FORCE  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_EN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PID_EN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_SPEED,
    S_MAC,
    S_PID,
    S_MOVE,
    S_RESULT
  } state_t;

endpackage

[rtl/epmc_if.sv]
// ----------------------------------------------------------------------------
// epmc_if: command and result channels
// Valid/ready channels carrying one command item and one result item.
// ----------------------------------------------------------------------------
interface epmc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic               motor;
  logic [31:0]        timer_value;
  logic               phase_b;
  logic signed [15:0] value;
  logic signed [31:0] step_distance;

  modport source (output valid, cmd, motor, timer_value, phase_b, value, step_distance,
                  input ready);
  modport sink (input valid, cmd, motor, timer_value, phase_b, value, step_distance,
                output ready);
endinterface

interface epmc_out_if;
  logic               valid;
  logic               ready;
  logic               motor_out;
  logic signed [15:0] measured_speed;
  logic signed [10:0] drive_force;
  logic [9:0]         duty_a;
  logic [9:0]         duty_b;
  logic               moving;
  logic signed [31:0] position;

  modport source (output valid, motor_out, measured_speed, drive_force, duty_a, duty_b,
                  moving, position, input ready);
  modport sink (input valid, motor_out, measured_speed, drive_force, duty_a, duty_b,
                moving, position, output ready);
endinterface

[rtl/encoder_pid_motor_controller_core.sv]
// ----------------------------------------------------------------------------
// encoder_pid_motor_controller_core: encoder speed loop with incremental PID
// Per-motor speed measurement, PID, PWM duty split and stepping moves.
// ----------------------------------------------------------------------------
// Usage: command items arrive on cmd_chan; each accepted transaction gives
// exactly one result transaction on result_chan describing the addressed
// motor after the command. The user must write registers through cfg_we,
// cfg_index and cfg_data only while the block is idle; it is not enforced.
// Sequence: an edge, move, target, clear or force command is accepted in the
// idle state, executed in the execute state and its result loaded into the
// output register in the result state, before the next command is taken. A
// control tick with a non-zero interval and PID enabled also passes through
// the divide, speed, multiply-accumulate, PID and move states, waiting on the
// bit-serial divider and on the shared multiplier stepping through the three
// PID products and the final sum. A tick without an edge, with a zero interval
// or with PID disabled skips the unit concerned.
// Throughput: one item at a time; cmd_chan.ready is high only while the
// sequencer waits for a new command.
// The result sits in an output register; a new command is accepted while it
// waits, and the sequencer holds the next result until the receiver has
// taken the previous one.
// Reset (synchronous, rst high) clears all per-motor state, empties the
// output register and loads the register defaults.
// ----------------------------------------------------------------------------
module encoder_pid_motor_controller_core #(
  parameter int MOTORS     = epmc_pkg::MOTORS_DEF,
  parameter int MAX_FORCE  = epmc_pkg::MAX_FORCE_DEF,
  parameter int PWM_PERIOD = epmc_pkg::PWM_PERIOD_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  epmc_in_if.sink                           cmd_chan,
  epmc_out_if.source                        result_chan,
  input  logic                              cfg_we,
  input  logic [epmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [epmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int MIDX    = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int FW      = $clog2(MAX_FORCE + 1) + 1;
  localparam int RATIO   = PWM_PERIOD / MAX_FORCE;
  localparam int RESET_L = epmc_pkg::PID_RESET_MAG * 256;

  // Configuration registers.
  logic signed [15:0] coef_a, coef_b, coef_c, limit_max, limit_min;
  logic               limit_enable, pid_enable;
  logic [31:0]        speed_scale;

  // Per-motor state.
  logic [31:0]        last_capture   [MOTORS];
  logic [31:0]        edge_interval  [MOTORS];
  logic               edge_seen      [MOTORS];
  logic               going_backward [MOTORS];
  logic [31:0]        step_position  [MOTORS];
  logic [31:0]        step_goal      [MOTORS];
  logic               move_active    [MOTORS];
  logic               move_upward    [MOTORS];
  logic signed [15:0] move_speed     [MOTORS];
  logic signed [15:0] target_speed   [MOTORS];
  logic signed [31:0] pid_accum      [MOTORS];
  logic signed [17:0] err_last       [MOTORS];
  logic signed [17:0] err_prev       [MOTORS];
  logic signed [15:0] speed_now      [MOTORS];
  logic signed [FW-1:0] force_now    [MOTORS];

  // Captured command.
  logic [2:0]         cmd;
  logic               motor;
  logic [31:0]        timer_value;
  logic               phase_b;
  logic signed [15:0] value;
  logic signed [31:0] step_distance;

  epmc_pkg::state_t   state, state_next;
  logic signed [15:0] spd;
  logic [MIDX-1:0]    mi;
  logic               motor_ok;

  logic        div_start, div_done, mac_start, mac_done;
  logic [31:0] div_quot;
  logic signed [35:0] mac_sum;
  logic signed [17:0] err_cur;
  logic signed [31:0] acc_base;

  assign mi       = MIDX'(motor);
  assign motor_ok = (32'(motor) < 32'(MOTORS));

  assign err_cur  = 18'(spd) - 18'(target_speed[mi]);
  // An accumulator that has run up to the reset magnitude starts again from zero.
  assign acc_base = (pid_accum[mi] >= 32'(RESET_L) || pid_accum[mi] <= -32'(RESET_L))
                    ? 32'sd0 : pid_accum[mi];

  epmc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (speed_scale),
    .den  (edge_interval[mi]),
    .done (div_done),
    .quot (div_quot)
  );

  epmc_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .start(mac_start),
    .base (acc_base),
    .coef0(coef_a),
    .coef1(coef_b),
    .coef2(coef_c),
    .err0 (err_cur),
    .err1 (err_last[mi]),
    .err2 (err_prev[mi]),
    .done (mac_done),
    .sum  (mac_sum)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      epmc_pkg::S_IDLE: begin
        if (cmd_chan.valid) state_next = epmc_pkg::S_EXEC;
      end
      epmc_pkg::S_EXEC: begin
        if (motor_ok && cmd == epmc_pkg::CMD_TICK) begin
          if (edge_seen[mi] && edge_interval[mi] != 32'd0) state_next = epmc_pkg::S_DIV;
          else state_next = epmc_pkg::S_SPEED;
        end else begin
          state_next = epmc_pkg::S_RESULT;
        end
      end
      epmc_pkg::S_DIV: begin
        if (div_done) state_next = epmc_pkg::S_SPEED;
      end
      epmc_pkg::S_SPEED: begin
        state_next = pid_enable ? epmc_pkg::S_MAC : epmc_pkg::S_MOVE;
      end
      epmc_pkg::S_MAC: begin
        if (mac_done) state_next = epmc_pkg::S_PID;
      end
      epmc_pkg::S_PID:  state_next = epmc_pkg::S_MOVE;
      epmc_pkg::S_MOVE: state_next = epmc_pkg::S_RESULT;
      epmc_pkg::S_RESULT: begin
        if (!result_chan.valid || result_chan.ready) state_next = epmc_pkg::S_IDLE;
      end
      default: state_next = epmc_pkg::S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    cmd_chan.ready = 1'b0;
    div_start      = 1'b0;
    mac_start      = 1'b0;
    case (state)
      epmc_pkg::S_IDLE: cmd_chan.ready = 1'b1;
      epmc_pkg::S_EXEC: begin
        div_start = motor_ok && cmd == epmc_pkg::CMD_TICK && edge_seen[mi]
                    && edge_interval[mi] != 32'd0;
      end
      epmc_pkg::S_SPEED: mac_start = pid_enable;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= epmc_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a       <= '0;
      coef_b       <= '0;
      coef_c       <= '0;
      limit_enable <= 1'b0;
      limit_max    <= 16'sd32767;
      limit_min    <= -16'sd32768;
      pid_enable   <= 1'b1;
      speed_scale  <= 32'd1000000;
    end else if (cfg_we) begin
      case (cfg_index)
        epmc_pkg::REG_COEF_A:    coef_a       <= cfg_data[15:0];
        epmc_pkg::REG_COEF_B:    coef_b       <= cfg_data[15:0];
        epmc_pkg::REG_COEF_C:    coef_c       <= cfg_data[15:0];
        epmc_pkg::REG_LIMIT_EN:  limit_enable <= cfg_data[0];
        epmc_pkg::REG_LIMIT_MAX: limit_max    <= cfg_data[15:0];
        epmc_pkg::REG_LIMIT_MIN: limit_min    <= cfg_data[15:0];
        epmc_pkg::REG_PID_EN:    pid_enable   <= cfg_data[0];
        epmc_pkg::REG_SCALE:     speed_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  // PID finishing arithmetic, used in the PID state once the products are summed.
  logic signed [31:0] acc_sat, acc_lim, acc_q;
  logic signed [31:0] lim_hi, lim_lo, frc_full;
  logic signed [FW-1:0] frc_pid, frc_cmd;

  always_comb begin
    if (mac_sum > 36'sh07FFFFFFF)       acc_sat = 32'sh7FFFFFFF;
    else if (mac_sum < -36'sh080000000) acc_sat = 32'sh80000000;
    else                                acc_sat = mac_sum[31:0];
    lim_hi  = 32'(limit_max) <<< 8;
    lim_lo  = 32'(limit_min) <<< 8;
    acc_lim = acc_sat;
    if (limit_enable) begin
      if (acc_sat > lim_hi)      acc_lim = lim_hi;
      else if (acc_sat < lim_lo) acc_lim = lim_lo;
    end
    // Division by 256 rounded toward zero.
    acc_q = acc_lim[31] ? ((acc_lim + 32'sd255) >>> 8) : (acc_lim >>> 8);
    if (acc_q > 32'(MAX_FORCE))       frc_pid = FW'(MAX_FORCE);
    else if (acc_q < -32'(MAX_FORCE)) frc_pid = FW'(-MAX_FORCE);
    else                              frc_pid = acc_q[FW-1:0];
    frc_full = 32'(value);
    if (frc_full > 32'(MAX_FORCE))       frc_cmd = FW'(MAX_FORCE);
    else if (frc_full < -32'(MAX_FORCE)) frc_cmd = FW'(-MAX_FORCE);
    else                                 frc_cmd = frc_full[FW-1:0];
  end

  // Move start: speed sign follows the sign of the distance.
  logic signed [15:0] mv_spd;
  always_comb begin
    mv_spd = value;
    if ((value > 16'sd0 && step_distance < 32'sd0) ||
        (value < 16'sd0 && step_distance > 32'sd0)) begin
      mv_spd = (value == -16'sd32768) ? 16'sd32767 : -value;
    end
  end

  logic [15:0] q_sat;
  assign q_sat = (div_quot > 32'd32767) ? 16'd32767 : div_quot[15:0];

  // Result fields from the addressed motor.
  logic signed [31:0] frc_ext;
  logic [31:0]        mag, duty;
  assign frc_ext = 32'(force_now[mi]);
  assign mag     = frc_ext[31] ? 32'(-frc_ext) : 32'(frc_ext);
  assign duty    = mag * 32'(RATIO);

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        last_capture[i]   <= '0;
        edge_interval[i]  <= '0;
        edge_seen[i]      <= 1'b0;
        going_backward[i] <= 1'b0;
        step_position[i]  <= '0;
        step_goal[i]      <= '0;
        move_active[i]    <= 1'b0;
        move_upward[i]    <= 1'b0;
        move_speed[i]     <= '0;
        target_speed[i]   <= '0;
        pid_accum[i]      <= '0;
        err_last[i]       <= '0;
        err_prev[i]       <= '0;
        speed_now[i]      <= '0;
        force_now[i]      <= '0;
      end
      result_chan.valid <= 1'b0;
    end else begin
      // In the result state the register is either reloaded or left alone.
      if (state != epmc_pkg::S_RESULT && result_chan.valid && result_chan.ready)
        result_chan.valid <= 1'b0;
      case (state)
        epmc_pkg::S_IDLE: begin
          if (cmd_chan.valid) begin
            cmd           <= cmd_chan.cmd;
            motor         <= cmd_chan.motor;
            timer_value   <= cmd_chan.timer_value;
            phase_b       <= cmd_chan.phase_b;
            value         <= cmd_chan.value;
            step_distance <= cmd_chan.step_distance;
          end
        end
        epmc_pkg::S_EXEC: begin
          if (motor_ok) begin
            case (cmd)
              epmc_pkg::CMD_EDGE: begin
                edge_interval[mi]  <= last_capture[mi] - timer_value;
                last_capture[mi]   <= timer_value;
                going_backward[mi] <= phase_b;
                step_position[mi]  <= phase_b ? step_position[mi] - 32'd1
                                              : step_position[mi] + 32'd1;
                edge_seen[mi]      <= 1'b1;
              end
              epmc_pkg::CMD_TICK: begin
                // No edge gives zero speed; a zero interval saturates.
                if (!edge_seen[mi])            spd <= '0;
                else if (going_backward[mi])   spd <= -16'sd32767;
                else                           spd <= 16'sd32767;
              end
              epmc_pkg::CMD_MOVE: begin
                if (!move_active[mi]) begin
                  move_upward[mi] <= (step_distance > 32'sd0);
                  move_active[mi] <= 1'b1;
                  step_goal[mi]   <= step_position[mi] + step_distance;
                  move_speed[mi]  <= mv_spd;
                end
              end
              epmc_pkg::CMD_TARGET: target_speed[mi] <= value;
              epmc_pkg::CMD_CLEAR: begin
                pid_accum[mi]    <= '0;
                target_speed[mi] <= '0;
                err_last[mi]     <= '0;
                err_prev[mi]     <= '0;
              end
              epmc_pkg::CMD_FORCE: force_now[mi] <= frc_cmd;
              default: ;
            endcase
          end
        end
        epmc_pkg::S_DIV: begin
          if (div_done) spd <= going_backward[mi] ? -signed'(q_sat) : signed'(q_sat);
        end
        epmc_pkg::S_SPEED: begin
          speed_now[mi] <= spd;
          edge_seen[mi] <= 1'b0;
          if (pid_enable) begin
            err_prev[mi] <= err_last[mi];
            err_last[mi] <= err_cur;
          end
        end
        epmc_pkg::S_PID: begin
          pid_accum[mi] <= acc_lim;
          force_now[mi] <= frc_pid;
        end
        epmc_pkg::S_MOVE: begin
          if (move_active[mi]) begin
            if (move_upward[mi] ? ($signed(step_position[mi]) > $signed(step_goal[mi]))
                                : ($signed(step_position[mi]) < $signed(step_goal[mi]))) begin
              move_active[mi]  <= 1'b0;
              target_speed[mi] <= '0;
            end else begin
              target_speed[mi] <= move_speed[mi];
            end
          end
        end
        epmc_pkg::S_RESULT: begin
          if (!result_chan.valid || result_chan.ready) begin
            result_chan.valid     <= 1'b1;
            result_chan.motor_out <= motor;
            if (motor_ok) begin
              result_chan.measured_speed <= speed_now[mi];
              result_chan.drive_force    <= frc_ext[10:0];
              result_chan.duty_a         <= (frc_ext > 32'sd0) ? duty[9:0] : 10'd0;
              result_chan.duty_b         <= (frc_ext < 32'sd0) ? duty[9:0] : 10'd0;
              result_chan.moving         <= move_active[mi];
              result_chan.position       <= step_position[mi];
            end else begin
              result_chan.measured_speed <= '0;
              result_chan.drive_force    <= '0;
              result_chan.duty_a         <= '0;
              result_chan.duty_b         <= '0;
              result_chan.moving         <= 1'b0;
              result_chan.position       <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/epmc_div.sv]
// ----------------------------------------------------------------------------
// epmc_div: iterative unsigned divider
// Restoring 32 by 32 bit division, one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module epmc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);

  logic [32:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], quot[31]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        quot <= num;
        dvs  <= den;
      end else if (busy) begin
        // The quotient register doubles as the dividend shift register.
        if (!trial[32]) begin
          rem  <= trial;
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem  <= shifted;
          quot <= {quot[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/epmc_mac.sv]
// ----------------------------------------------------------------------------
// epmc_mac: sequential multiply-accumulate
// Adds three coefficient-times-error products to a base, one multiply a cycle while busy.
// ----------------------------------------------------------------------------
module epmc_mac (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] base,
  input  logic signed [15:0] coef0,
  input  logic signed [15:0] coef1,
  input  logic signed [15:0] coef2,
  input  logic signed [17:0] err0,
  input  logic signed [17:0] err1,
  input  logic signed [17:0] err2,
  output logic               done,
  output logic signed [35:0] sum
);

  logic signed [15:0] c_q [3];
  logic signed [17:0] e_q [3];
  logic signed [33:0] prod;
  logic               prod_vld;
  logic [1:0]         step;
  logic               busy;
  logic signed [15:0] c_sel;
  logic signed [17:0] e_sel;

  always_comb begin
    case (step)
      2'd0:    begin c_sel = c_q[0]; e_sel = e_q[0]; end
      2'd1:    begin c_sel = c_q[1]; e_sel = e_q[1]; end
      2'd2:    begin c_sel = c_q[2]; e_sel = e_q[2]; end
      default: begin c_sel = '0;     e_sel = '0;     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      prod_vld <= 1'b0;
      step     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        prod_vld <= 1'b0;
        sum      <= 36'(base);
        c_q[0]   <= coef0;
        c_q[1]   <= coef1;
        c_q[2]   <= coef2;
        e_q[0]   <= err0;
        e_q[1]   <= err1;
        e_q[2]   <= err2;
      end else if (busy) begin
        prod     <= c_sel * e_sel;
        prod_vld <= (step != 2'd3);
        if (prod_vld) begin
          sum <= sum + 36'(prod);
        end
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 2'd1;
        end
      end
    end
  end

endmodule

[rtl/epmc_checker.sv]
// ----------------------------------------------------------------------------
// epmc_checker: port-level checks of the motor controller
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module epmc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [10:0] drive_force,
  input logic [9:0]         duty_a,
  input logic [9:0]         duty_b,
  input logic signed [31:0] position
);

  // The result register is empty after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(drive_force))
    else $error("stalled result changed");

  // Once a command is taken the block is busy in the cycle after.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken back to back");

  // Only one PWM channel is driven.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_a == 10'd0 || duty_b == 10'd0))
    else $error("both duties non-zero");

  // Zero force drives neither channel.
  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_force == 11'sd0 |-> duty_a == 10'd0 && duty_b == 10'd0)
    else $error("duty without force");

endmodule

bind encoder_pid_motor_controller_core epmc_checker u_epmc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cmd_chan.valid),
  .in_ready   (cmd_chan.ready),
  .out_valid  (result_chan.valid),
  .out_ready  (result_chan.ready),
  .drive_force(result_chan.drive_force),
  .duty_a     (result_chan.duty_a),
  .duty_b     (result_chan.duty_b),
  .position   (result_chan.position)
);
